FILE: src/kat_pkg.sv
// Shared types and constants for the keepalive timeout table.
package kat_pkg;

    // Table geometry.
    localparam int SLOTS  = 64;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int LIVE_W = 7;
    localparam int SLOT_W = 6;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int MISS_W = 4;
    localparam int TMO_W  = 16;
    localparam int CFG_W  = 16;

    localparam logic [MISS_W-1:0] MISS_MAX      = '1;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd1;
    localparam logic [MISS_W-1:0] LIMIT_RESET   = 4'd3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_LIMIT   = 1'b1
    } t_cfg_idx;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_SCAN    = 2'd3
    } t_op;

    // What the slot walk is doing with each slot it reads.
    typedef enum logic [1:0] {
        M_IDLE,
        M_FIND,
        M_COUNT,
        M_APPLY
    } t_mode;

    // One word of slot memory.
    typedef struct packed {
        logic [ID_W-1:0]   conn_id;
        logic [MISS_W-1:0] misses;
        logic [TIME_W-1:0] last_seen;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             ev_vld;
        logic [IDX_W-1:0] ev_idx;
        logic             ev_last;
        t_mode            mode;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
    } t_status;

endpackage

FILE: src/kat_ctrl.sv
// Controller: sequences the slot walks for each operation.
module kat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_operation,
    input  kat_pkg::t_status i_status,
    output kat_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_COUNT,
        S_APPLY
    } t_state;

    t_state                      r_state, n_state;
    logic [kat_pkg::CNT_W-1:0]   r_rd_cnt, n_rd_cnt;
    logic                        r_ev_vld, n_ev_vld;
    logic [kat_pkg::IDX_W-1:0]   r_ev_idx, n_ev_idx;
    logic                        w_issue;
    logic                        w_ev_last;
    logic                        w_accept;

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_issue   = (r_state != S_IDLE) && (r_rd_cnt < kat_pkg::CNT_W'(kat_pkg::SLOTS));
    assign w_ev_last = r_ev_idx == kat_pkg::IDX_W'(kat_pkg::SLOTS - 1);

    // Next state and walk pointer.
    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        n_ev_vld = 1'b0;
        n_ev_idx = r_ev_idx;
        if (w_issue) begin
            n_rd_cnt = r_rd_cnt + kat_pkg::CNT_W'(1);
            n_ev_vld = 1'b1;
            n_ev_idx = r_rd_cnt[kat_pkg::IDX_W-1:0];
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rd_cnt = '0;
                    if (kat_pkg::t_op'(i_operation) == kat_pkg::OP_SCAN) begin
                        n_state = S_COUNT;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (r_ev_vld && (i_status.hit || w_ev_last)) begin
                    n_state  = S_IDLE;
                    n_ev_vld = 1'b0;
                end
            end
            S_COUNT: begin
                // The counting pass is done; walk the table again to apply it.
                if (r_ev_vld && w_ev_last) begin
                    n_state  = S_APPLY;
                    n_rd_cnt = '0;
                    n_ev_vld = 1'b0;
                end
            end
            S_APPLY: begin
                if (r_ev_vld && w_ev_last) begin
                    n_state  = S_IDLE;
                    n_ev_vld = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_cnt <= '0;
            r_ev_vld <= 1'b0;
            r_ev_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_cnt <= n_rd_cnt;
            r_ev_vld <= n_ev_vld;
            r_ev_idx <= n_ev_idx;
        end
    end

    // Command bundle to the datapath.
    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.rd_en   = w_issue;
        o_cmd.rd_idx  = r_rd_cnt[kat_pkg::IDX_W-1:0];
        o_cmd.ev_vld  = r_ev_vld;
        o_cmd.ev_idx  = r_ev_idx;
        o_cmd.ev_last = w_ev_last;
        case (r_state)
            S_FIND:  o_cmd.mode = kat_pkg::M_FIND;
            S_COUNT: o_cmd.mode = kat_pkg::M_COUNT;
            S_APPLY: o_cmd.mode = kat_pkg::M_APPLY;
            default: o_cmd.mode = kat_pkg::M_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

endmodule

FILE: src/kat_datapath.sv
// Datapath: slot memory, active flags, configuration, slot checks and result register.
module kat_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kat_pkg::t_cmd              i_cmd,
    output kat_pkg::t_status           o_status,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [kat_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_operation,
    input  logic [kat_pkg::ID_W-1:0]   i_conn_id,
    input  logic [kat_pkg::TIME_W-1:0] i_now_time,
    output logic                       o_valid,
    output logic [1:0]                 o_result_kind,
    output logic                       o_success,
    output logic [kat_pkg::SLOT_W-1:0] o_slot_index,
    output logic [kat_pkg::ID_W-1:0]   o_evicted_id,
    output logic [kat_pkg::LIVE_W-1:0] o_live_count,
    output logic                       o_last
);

    kat_pkg::t_slot              r_mem [kat_pkg::SLOTS];
    kat_pkg::t_slot              r_rd_q;
    logic [kat_pkg::SLOTS-1:0]   r_active;
    logic [kat_pkg::TMO_W-1:0]   r_timeout;
    logic [kat_pkg::MISS_W-1:0]  r_limit;
    kat_pkg::t_op                r_op;
    logic [kat_pkg::ID_W-1:0]    r_id;
    logic [kat_pkg::TIME_W-1:0]  r_now;
    logic [kat_pkg::LIVE_W-1:0]  r_live;
    logic [kat_pkg::LIVE_W-1:0]  r_evict_cnt;
    logic                        r_valid;

    logic                        w_act;
    logic [kat_pkg::TIME_W-1:0]  w_elapsed;
    logic                        w_timed;
    logic [kat_pkg::MISS_W-1:0]  w_misses_nx;
    logic                        w_evict;
    logic                        w_match;
    logic                        w_hit;
    logic                        w_find_hit;
    logic                        w_find_fail;
    logic                        w_touch;
    logic                        w_apply_evict;
    logic                        w_apply_none;
    logic                        w_wr_en;
    kat_pkg::t_slot              w_wr_data;

    // Checks on the slot whose memory word has just been read.
    always_comb begin
        w_act       = r_active[i_cmd.ev_idx];
        w_elapsed   = r_now - r_rd_q.last_seen;
        w_timed     = w_elapsed >= {{(kat_pkg::TIME_W - kat_pkg::TMO_W){1'b0}}, r_timeout};
        w_misses_nx = (r_rd_q.misses == kat_pkg::MISS_MAX) ? kat_pkg::MISS_MAX
                                                           : r_rd_q.misses + 1'b1;
        w_evict     = w_act && w_timed && (w_misses_nx >= r_limit);
        w_match     = w_act && (r_rd_q.conn_id == r_id);
        case (i_cmd.mode)
            kat_pkg::M_FIND:  w_hit = (r_op == kat_pkg::OP_ADD) ? !w_act : w_match;
            kat_pkg::M_COUNT: w_hit = w_evict;
            kat_pkg::M_APPLY: w_hit = w_evict;
            default:          w_hit = 1'b0;
        endcase
    end

    assign o_status.hit = w_hit;

    // Actions taken on the slot under evaluation. A scan that evicts nothing reports
    // its single record on the first slot of the second pass.
    always_comb begin
        w_find_hit    = i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_FIND) && w_hit;
        w_find_fail   = i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_FIND) && i_cmd.ev_last
                        && !w_hit;
        w_touch       = i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_APPLY) && w_act && w_timed;
        w_apply_evict = i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_APPLY) && w_evict;
        w_apply_none  = i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_APPLY)
                        && (i_cmd.ev_idx == '0) && (r_evict_cnt == '0);
        w_wr_en       = 1'b0;
        w_wr_data     = r_rd_q;
        if (w_find_hit && (r_op == kat_pkg::OP_ADD)) begin
            w_wr_en   = 1'b1;
            w_wr_data = '{conn_id: r_id, misses: '0, last_seen: r_now};
        end else if (w_find_hit && (r_op == kat_pkg::OP_REFRESH)) begin
            w_wr_en   = 1'b1;
            w_wr_data = '{conn_id: r_rd_q.conn_id, misses: '0, last_seen: r_now};
        end else if (w_touch) begin
            w_wr_en   = 1'b1;
            w_wr_data = '{conn_id: r_rd_q.conn_id, misses: w_misses_nx, last_seen: r_now};
        end
    end

    // Slot memory: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_q <= r_mem[i_cmd.rd_idx];
        end
        if (w_wr_en) begin
            r_mem[i_cmd.ev_idx] <= w_wr_data;
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= kat_pkg::t_op'(i_operation);
            r_id  <= i_conn_id;
            r_now <= i_now_time;
        end
    end

    // Configuration, active flags, live count and eviction count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= kat_pkg::TIMEOUT_RESET;
            r_limit     <= kat_pkg::LIMIT_RESET;
            r_active    <= '0;
            r_live      <= '0;
            r_evict_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (kat_pkg::t_cfg_idx'(i_cfg_index))
                    kat_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[kat_pkg::TMO_W-1:0];
                    kat_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data[kat_pkg::MISS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_evict_cnt <= '0;
            end else if (i_cmd.ev_vld && (i_cmd.mode == kat_pkg::M_COUNT) && w_evict) begin
                r_evict_cnt <= r_evict_cnt + 1'b1;
            end else if (w_apply_evict) begin
                r_evict_cnt <= r_evict_cnt - 1'b1;
            end
            if (w_find_hit && (r_op == kat_pkg::OP_ADD)) begin
                r_active[i_cmd.ev_idx] <= 1'b1;
                r_live                 <= r_live + 1'b1;
            end else if ((w_find_hit && (r_op == kat_pkg::OP_DELETE)) || w_apply_evict) begin
                r_active[i_cmd.ev_idx] <= 1'b0;
                r_live                 <= r_live - 1'b1;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_find_hit || w_find_fail || w_apply_evict || w_apply_none;
        end
    end

    // Result payload. A scan record reports the count left once the whole scan is done.
    always_ff @(posedge i_clk) begin
        if (w_find_hit) begin
            o_result_kind <= r_op;
            o_success     <= 1'b1;
            o_slot_index  <= kat_pkg::SLOT_W'(i_cmd.ev_idx);
            o_evicted_id  <= r_id;
            o_last        <= 1'b1;
            case (r_op)
                kat_pkg::OP_ADD:    o_live_count <= r_live + 1'b1;
                kat_pkg::OP_DELETE: o_live_count <= r_live - 1'b1;
                default:            o_live_count <= r_live;
            endcase
        end else if (w_find_fail || w_apply_none) begin
            o_result_kind <= r_op;
            o_success     <= 1'b0;
            o_slot_index  <= '0;
            o_evicted_id  <= '0;
            o_live_count  <= r_live;
            o_last        <= 1'b1;
        end else if (w_apply_evict) begin
            o_result_kind <= r_op;
            o_success     <= 1'b1;
            o_slot_index  <= kat_pkg::SLOT_W'(i_cmd.ev_idx);
            o_evicted_id  <= r_rd_q.conn_id;
            o_live_count  <= r_live - r_evict_cnt;
            o_last        <= r_evict_cnt == kat_pkg::LIVE_W'(1);
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: src/connection_keepalive_timeout_table.sv
// Top level of the keepalive timeout table: controller and datapath.
//
// A request is taken when i_start is high while o_busy is low; results leave on the
// o_ ports, each for one cycle marked by o_valid, and the receiver cannot stall them.
// Every operation walks the 64-entry slot memory one slot a cycle through its single
// registered read port. Add, delete and refresh stop at the first hit, or report a
// failure after the last slot when nothing is found. A scan makes two full passes, one
// to count evictions so that each record can carry the final live count and the last
// flag, one to update the slots and emit the records, one per cycle. A scan that evicts
// nothing sends its single record on the first slot of the second pass and stays busy
// until the pass ends. Active flags are flip-flops cleared by reset, so there is no
// clearing pass after reset.
module connection_keepalive_timeout_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_operation,
    input  logic [kat_pkg::ID_W-1:0]   i_conn_id,
    input  logic [kat_pkg::TIME_W-1:0] i_now_time,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [kat_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output logic [1:0]                 o_result_kind,
    output logic                       o_success,
    output logic [kat_pkg::SLOT_W-1:0] o_slot_index,
    output logic [kat_pkg::ID_W-1:0]   o_evicted_id,
    output logic [kat_pkg::LIVE_W-1:0] o_live_count,
    output logic                       o_last
);

    kat_pkg::t_cmd    w_cmd;
    kat_pkg::t_status w_status;

    // Walk sequencer.
    kat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy)
    );

    // Slot storage and result generation.
    kat_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_conn_id     (i_conn_id),
        .i_now_time    (i_now_time),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_success     (o_success),
        .o_slot_index  (o_slot_index),
        .o_evicted_id  (o_evicted_id),
        .o_live_count  (o_live_count),
        .o_last        (o_last)
    );

endmodule

FILE: src/kat_checker.sv
// Port-level assertions for the keepalive timeout table, bound to the top level.
module kat_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic                       o_valid,
    input logic [1:0]                 o_result_kind,
    input logic                       o_success,
    input logic [kat_pkg::SLOT_W-1:0] o_slot_index,
    input logic [kat_pkg::ID_W-1:0]   o_evicted_id,
    input logic [kat_pkg::LIVE_W-1:0] o_live_count,
    input logic                       o_last
);

    // A start transfer always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after start transfer");

    // Results only follow a cycle in which the block was working.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without a pending request");

    // A failed result carries no slot and no id and ends its request.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_last && (o_slot_index == '0) && (o_evicted_id == '0)))
        else $error("malformed failure result");

    // Only a scan may produce more than one result.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind != kat_pkg::OP_SCAN)) |-> o_last)
        else $error("non-scan result without last flag");

    // The live count never exceeds the table size.
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_count <= kat_pkg::LIVE_W'(kat_pkg::SLOTS)))
        else $error("live count out of range");

endmodule

bind connection_keepalive_timeout_table kat_checker u_kat_checker (.*);
